[design/ots_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_pkg: shared types and constants of the odd-even transposition sorter
// Holds the key width, the default capacity, the cell operation codes and the
// control bundle that the controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package ots_pkg;

  localparam int KEY_W     = 32;
  localparam int DEPTH_DEF = 64;

  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_SORT  = 2'd2;
  localparam logic [1:0] OP_SHIFT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       odd;
  } cell_ctl_t;

endpackage

[design/odd_even_transposition_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter: chain-of-cells sorter for signed keys
// A set of n keys is loaded one per cycle and sorted in 2n phases, each
// doing one compare-exchange on every other neighboring pair, the even and
// odd pairs in turn; the keys are then emitted in ascending order at one
// key per cycle when not stalled. The input
// stalls from the item marked last until the final key of the set is taken.
// Keys beyond DEPTH are dropped and every result of that set is flagged.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter import ots_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [KEY_W-1:0] key_value,
  input  logic                    is_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [KEY_W-1:0] sorted_value,
  output logic                    is_final,
  output logic                    overflowed
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_ctl_t               ctl;
  logic [CNT_W-1:0]        count;
  logic signed [KEY_W-1:0] keys [DEPTH];

  ots_ctrl #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .is_last    (is_last),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_final   (is_final),
    .overflowed (overflowed),
    .ctl        (ctl),
    .count      (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;
    if (i == 0) begin : g_first
      assign left_key = key_value;
    end else begin : g_mid
      assign left_key = keys[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = keys[i+1];
    end
    ots_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[i])
    );
  end

  assign sorted_value = keys[0];

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while emitting");

  a_final_ends_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_final |=> !out_valid && !in_stall)
    else $error("emission continued after final item");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall && !out_valid)
    else $error("sort phase skipped");

  a_flag_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_final |=> out_valid && overflowed == $past(overflowed))
    else $error("overflow flag changed within a set");

endmodule

[design/ots_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_cell: one key cell of the sorting chain
// Loads from its left neighbor, does at most one compare-exchange per sort
// phase with a neighbor, and takes its right neighbor's key while draining.
// ----------------------------------------------------------------------------
module ots_cell import ots_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key
);

  localparam logic SELF_ODD = 1'(IDX % 2);
  localparam logic PREV_ODD = 1'((IDX + 1) % 2);
  localparam logic HAS_LEFT = (IDX > 0);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  logic                    left_act;
  logic                    right_act;
  logic signed [KEY_W-1:0] key_next;

  assign left_act  = (ctl.odd == SELF_ODD) && (NEXT_C < count);
  assign right_act = HAS_LEFT && (ctl.odd == PREV_ODD) && (IDX_C < count);

  always_comb begin
    key_next = key;
    case (ctl.op)
      OP_LOAD:  key_next = left_key;
      OP_SHIFT: key_next = right_key;
      OP_SORT: begin
        if (left_act && (key > right_key)) key_next = right_key;
        else if (right_act && (left_key > key)) key_next = left_key;
      end
      default: key_next = key;
    endcase
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

[design/ots_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_ctrl: sequencer of the sorting chain
// Counts loaded keys, steps through the compare phases and drains the sorted
// set, driving both handshakes and the cell operation bundle.
// ----------------------------------------------------------------------------
module ots_ctrl import ots_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             is_last,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_final,
  output logic             overflowed,
  output cell_ctl_t        ctl,
  output logic [CNT_W-1:0] count
);

  localparam int PH_W = $clog2(2 * DEPTH);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [1:0]       state;
  logic [PH_W-1:0]  phase;
  logic             in_acc;
  logic             out_acc;
  logic             room;
  logic [CNT_W:0]   two_n_m1;
  logic [PH_W-1:0]  last_phase;

  assign in_stall   = (state != ST_LOAD);
  assign out_valid  = (state == ST_EMIT);
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign room       = (count < DEPTH_C);
  assign is_final   = (count == CNT_W'(1));
  assign two_n_m1   = {count, 1'b0} - (CNT_W + 1)'(1);
  assign last_phase = PH_W'(two_n_m1);

  always_comb begin
    ctl.odd = phase[0];
    ctl.op  = OP_HOLD;
    case (state)
      ST_LOAD: if (in_acc && room) ctl.op = OP_LOAD;
      ST_SORT: ctl.op = OP_SORT;
      ST_EMIT: if (out_acc) ctl.op = OP_SHIFT;
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      overflowed <= 1'b0;
      phase      <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) count <= count + CNT_W'(1);
            else overflowed <= 1'b1;
            if (is_last) begin
              phase <= '0;
              state <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + PH_W'(1);
          if (phase == last_phase) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            count <= count - CNT_W'(1);
            if (is_final) begin
              overflowed <= 1'b0;
              state      <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

[tb/odd_even_transposition_sorter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_test: self-checking bench for the key sorter
// Feeds sets of signed keys, each closed by an item marked last, and checks
// every emitted key, end-of-set mark and overflow flag against a local sort
// of the same set. Covers single-key sets, extreme and equal keys, full and
// overflowing sets, with random idle bursts on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [ots_pkg::KEY_W-1:0] key;
  logic                             tail;
  logic                             dropped;
} sorted_key_t;

class sort_scoreboard;
  logic signed [ots_pkg::KEY_W-1:0] set_keys[$];
  bit                               set_dropped;
  sorted_key_t                      sorted_q[$];
  int                               capacity;
  int                               mismatches;
  int                               keys_seen;
  int                               sets_seen;
  int                               dropped_sets;
  int                               results_seen;

  function new(int depth);
    capacity     = depth;
    set_dropped  = 0;
    mismatches   = 0;
    keys_seen    = 0;
    sets_seen    = 0;
    dropped_sets = 0;
    results_seen = 0;
  endfunction

  function int pending();
    return sorted_q.size();
  endfunction

  // Store the key if the set has room, and on the last one sort the set and queue its results.
  function void note_key(logic signed [ots_pkg::KEY_W-1:0] key, logic last);
    logic signed [ots_pkg::KEY_W-1:0] swap;
    int                               n;
    sorted_key_t                      res;
    keys_seen++;
    if (set_keys.size() < capacity) set_keys.push_back(key);
    else set_dropped = 1;
    if (!last) return;
    n = set_keys.size();
    for (int r = 0; r < n; r++) begin
      for (int ph = 0; ph < 2; ph++) begin
        for (int i = ph; i + 1 < n; i += 2) begin
          if (set_keys[i] > set_keys[i+1]) begin
            swap          = set_keys[i];
            set_keys[i]   = set_keys[i+1];
            set_keys[i+1] = swap;
          end
        end
      end
    end
    for (int j = 0; j < n; j++) begin
      res.key     = set_keys[j];
      res.tail    = (j == n - 1);
      res.dropped = set_dropped;
      sorted_q.push_back(res);
    end
    sets_seen++;
    if (set_dropped) dropped_sets++;
    set_keys.delete();
    set_dropped = 0;
  endfunction

  function void check_result(logic signed [ots_pkg::KEY_W-1:0] key, logic tail,
                             logic dropped);
    sorted_key_t exp_res;
    results_seen++;
    if (sorted_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result key=%0d final=%0b overflowed=%0b",
                 key, tail, dropped);
      return;
    end
    exp_res = sorted_q.pop_front();
    if (key !== exp_res.key || tail !== exp_res.tail || dropped !== exp_res.dropped) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d exp key=%0d fin=%0b ovf=%0b, got key=%0d fin=%0b ovf=%0b",
                 results_seen, exp_res.key, exp_res.tail, exp_res.dropped, key, tail,
                 dropped);
    end
  endfunction
endclass

module odd_even_transposition_sorter_test;
  import ots_pkg::*;

  localparam int                SORT_DEPTH = DEPTH_DEF;
  localparam int                QUIET_LIMIT = 2000;
  localparam int                RANDOM_KEYS = 150;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [KEY_W-1:0] key_value = '0;
  logic                    is_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [KEY_W-1:0] sorted_value;
  logic                    is_final;
  logic                    overflowed;

  sort_scoreboard          sb = new(SORT_DEPTH);
  logic signed [KEY_W-1:0] set_buf[$];
  bit                      in_bursts = 0;
  bit                      out_bursts = 0;
  bit                      calm = 0;
  int                      stall_left = 0;
  int                      quiet = 0;

  odd_even_transposition_sorter #(.DEPTH(SORT_DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key_value   (key_value),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .is_final    (is_final),
    .overflowed  (overflowed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || calm || !out_bursts) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(sorted_value, is_final, overflowed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("odd_even_transposition_sorter_test: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_key(input logic signed [KEY_W-1:0] key, input logic last);
    if (in_bursts && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    key_value <= key;
    is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_key(key, last);
  endtask

  task automatic send_set();
    in_bursts  = $urandom_range(0, 2) != 0;
    out_bursts = $urandom_range(0, 2) != 0;
    for (int i = 0; i < set_buf.size(); i++) send_key(set_buf[i], i == set_buf.size() - 1);
  endtask

  initial begin
    int n;
    int sent;
    int set_idx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_buf = '{32'sd5};
    send_set();
    set_buf = '{KEY_MAX, KEY_MIN};
    send_set();
    set_buf = '{KEY_MAX, KEY_MIN, 32'sd0, -32'sd1, 32'sd1};
    send_set();
    set_buf = '{32'sd3, 32'sd3, -32'sd3, 32'sd3};
    send_set();
    set_buf = '{32'sd8, 32'sd7, 32'sd6, 32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1};
    send_set();

    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_KEYS) begin
      if (set_idx == 0) n = SORT_DEPTH + $urandom_range(1, 4);
      else if (set_idx == 1) n = SORT_DEPTH;
      else n = $urandom_range(1, 12);
      set_buf.delete();
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0:       set_buf.push_back($signed($urandom_range(0, 8)) - 4);
          1:       set_buf.push_back($urandom_range(0, 1) ? KEY_MIN : KEY_MAX);
          default: set_buf.push_back($urandom);
        endcase
      end
      if (sent > RANDOM_KEYS - 30) calm = 1;
      send_set();
      sent += n;
      set_idx++;
    end
    in_valid <= 1'b0;
    calm = 1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run: %0d keys in %0d sets (%0d with dropped keys), %0d sorted keys checked",
             sb.keys_seen, sb.sets_seen, sb.dropped_sets, sb.results_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("odd_even_transposition_sorter_test: clean");
    end else begin
      $display("odd_even_transposition_sorter_test: errors");
    end
    $finish;
  end
endmodule
